// File: src/owbg_pkg.sv
// Shared types, constants and the divider step for the white-balance gain block.
package owbg_pkg;

  // Field widths
  localparam int RAT_W     = 10;  // raw ratio and light factor
  localparam int FIX_W     = 11;  // ratio after light correction
  localparam int GOLD_W    = 10;  // golden ratio registers
  localparam int GAIN_W    = 24;  // saturated gain
  localparam int NUM_W     = 32;  // divider numerator and quotient
  localparam int DEN_W     = 11;  // divider denominator and remainder
  localparam int DIV_STEPS = NUM_W;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h000400;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'hFFFFFF;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  // Ratio cases against the golden ratios
  localparam logic [1:0] K_LOW_BOTH  = 2'd0;  // rg and bg below golden
  localparam logic [1:0] K_HIGH_RG   = 2'd1;  // rg at or above, bg below
  localparam logic [1:0] K_HIGH_BG   = 2'd2;  // bg at or above, rg below
  localparam logic [1:0] K_HIGH_BOTH = 2'd3;  // both at or above

  // Which gain the second division produces
  localparam logic [1:0] T_NONE = 2'd0;
  localparam logic [1:0] T_RED  = 2'd1;
  localparam logic [1:0] T_BLUE = 2'd2;

  typedef struct packed {
    logic [7:0] group_flag;
    logic [7:0] rg_high;
    logic [7:0] bg_high;
    logic [7:0] light_rg_high;
    logic [7:0] light_bg_high;
    logic [7:0] low_bits;
  } in_t;

  typedef struct packed {
    logic [GAIN_W-1:0] red_gain;
    logic [GAIN_W-1:0] green_gain;
    logic [GAIN_W-1:0] blue_gain;
    logic              red_apply;
    logic              green_apply;
    logic              blue_apply;
    logic [1:0]        status;
  } out_t;

  // One restoring-division lane
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
  } lane_t;

  // Item context carried alongside the divider lanes
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        kind;
    logic [1:0]        tgt;
    logic [FIX_W-1:0]  rg;
    logic [FIX_W-1:0]  bg;
    logic [GOLD_W-1:0] grg;
    logic [GOLD_W-1:0] gbg;
    logic [NUM_W-1:0]  red;
    logic [NUM_W-1:0]  grn;
    logic [NUM_W-1:0]  blu;
  } ctx_t;

  typedef struct packed {
    ctx_t  ctx;
    lane_t lane0;
    lane_t lane1;
  } stage_t;

  // One quotient bit: shift in the next numerator bit, subtract if it fits
  function automatic lane_t div_step(lane_t l);
    lane_t            o;
    logic [DEN_W:0]   r2;
    logic             fit;
    o   = l;
    r2  = {l.rem, l.num[NUM_W-1]};
    fit = (r2 >= {1'b0, l.den});
    o.rem = fit ? DEN_W'(r2 - {1'b0, l.den}) : r2[DEN_W-1:0];
    o.num = {l.num[NUM_W-2:0], 1'b0};
    o.quo = {l.quo[NUM_W-2:0], fit};
    return o;
  endfunction

  // Clamp a quotient to the gain width
  function automatic logic [GAIN_W-1:0] sat_gain(logic [NUM_W-1:0] v);
    return (v > NUM_W'(GAIN_MAX)) ? GAIN_MAX : v[GAIN_W-1:0];
  endfunction

endpackage

// File: src/owbg_div_cell.sv
// One divider cell: resolves one quotient bit for both lanes and passes the item on.
module owbg_div_cell import owbg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output stage_t out_data
);

  logic   valid_r;
  stage_t data_r;

  // valid bit is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload: one division step per lane
  always_ff @(posedge clk) begin
    data_r.ctx   <= in_data.ctx;
    data_r.lane0 <= div_step(in_data.lane0);
    data_r.lane1 <= div_step(in_data.lane1);
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: src/owbg_div_chain.sv
// Row of divider cells giving a full quotient.
module owbg_div_chain import owbg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output stage_t out_data
);

  logic   v [0:DIV_STEPS];
  stage_t d [0:DIV_STEPS];

  assign v[0] = in_valid;
  assign d[0] = in_data;

  // each cell hands its item to the next
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    owbg_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[i]),
      .in_data   (d[i]),
      .out_valid (v[i+1]),
      .out_data  (d[i+1])
    );
  end

  assign out_valid = v[DIV_STEPS];
  assign out_data  = d[DIV_STEPS];

endmodule

// File: src/otp_white_balance_gain.sv
// Top level of the OTP white-balance gain calculator.
// One item is taken in every clock cycle (busy stays low) and its result
// appears on out_item with out_strobe high for one cycle. Each item passes
// through a decode stage, two rows of 32 restoring-division cells (one
// quotient bit per cell) with a multiply stage between them, and an output
// register. The receiver cannot stall, so results must be taken when strobed.
// Golden ratios must be written over the APB port only while no item is in
// flight; the block itself does not enforce this.
module otp_white_balance_gain import owbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        start,
  output logic        busy,
  input  in_t         in_item,
  // result output
  output logic        out_strobe,
  output out_t        out_item,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GOLD_W-1:0] grg_r;
  logic [GOLD_W-1:0] gbg_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grg_r <= GOLD_W'(279);
      gbg_r <= GOLD_W'(275);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        gbg_r <= pwdata[GOLD_W-1:0];
      end else begin
        grg_r <= pwdata[GOLD_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(gbg_r) : 32'(grg_r);
  assign busy   = 1'b0;

  // decode and light correction
  logic [RAT_W-1:0]  rg_raw, bg_raw, lrg, lbg;
  logic [20:0]       rg_prod, bg_prod;
  ctx_t              dec_ctx;

  always_comb begin
    rg_raw  = {in_item.rg_high, in_item.low_bits[7:6]};
    bg_raw  = {in_item.bg_high, in_item.low_bits[5:4]};
    lrg     = {in_item.light_rg_high, in_item.low_bits[3:2]};
    lbg     = {in_item.light_bg_high, in_item.low_bits[1:0]};
    rg_prod = 21'(rg_raw) * (21'(lrg) + 21'd512);
    bg_prod = 21'(bg_raw) * (21'(lbg) + 21'd512);
    dec_ctx = '0;
    dec_ctx.grg = grg_r;
    dec_ctx.gbg = gbg_r;
    dec_ctx.rg  = (lrg == '0) ? FIX_W'(rg_raw) : rg_prod[20:10];
    dec_ctx.bg  = (lbg == '0) ? FIX_W'(bg_raw) : bg_prod[20:10];
    priority if (in_item.group_flag[7:6] == 2'b00) begin
      dec_ctx.status = ST_EMPTY;
    end else if (in_item.group_flag[7]) begin
      dec_ctx.status = ST_INVALID;
    end else if (dec_ctx.rg == '0 || dec_ctx.bg == '0 || grg_r == '0 || gbg_r == '0) begin
      dec_ctx.status = ST_ZERO;
    end else begin
      dec_ctx.status = ST_OK;
    end
  end

  logic s0_valid_r;
  ctx_t s0_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_ctx_r <= dec_ctx;
  end

  // pick the first divisions from the ratio case
  stage_t a_in;
  logic   bg_low, rg_low;

  always_comb begin
    bg_low = ({1'b0, s0_ctx_r.gbg} > s0_ctx_r.bg);
    rg_low = ({1'b0, s0_ctx_r.grg} > s0_ctx_r.rg);
    a_in = '0;
    a_in.ctx = s0_ctx_r;
    a_in.ctx.kind = {!bg_low, !rg_low};
    a_in.lane0.den = 11'd1;
    a_in.lane1.den = 11'd1;
    unique case ({!bg_low, !rg_low})
      K_LOW_BOTH: begin
        a_in.lane0.num = {11'b0, s0_ctx_r.grg, 1'b0, 10'b0};
        a_in.lane0.den = s0_ctx_r.rg;
        a_in.lane1.num = {11'b0, s0_ctx_r.gbg, 1'b0, 10'b0} >> 1;
        a_in.lane1.den = s0_ctx_r.bg;
        a_in.lane0.num = a_in.lane0.num >> 1;
      end
      K_HIGH_RG: begin
        a_in.lane0.num = {10'b0, s0_ctx_r.rg, 11'b0} >> 1;
        a_in.lane0.den = {1'b0, s0_ctx_r.grg};
      end
      K_HIGH_BG: begin
        a_in.lane0.num = {10'b0, s0_ctx_r.bg, 11'b0} >> 1;
        a_in.lane0.den = {1'b0, s0_ctx_r.gbg};
      end
      K_HIGH_BOTH: begin
        a_in.lane0.num = {10'b0, s0_ctx_r.rg, 11'b0} >> 1;
        a_in.lane0.den = {1'b0, s0_ctx_r.grg};
        a_in.lane1.num = {10'b0, s0_ctx_r.bg, 11'b0} >> 1;
        a_in.lane1.den = {1'b0, s0_ctx_r.gbg};
      end
      default: begin
        a_in.lane0.den = 11'd1;
      end
    endcase
  end

  logic   a_valid;
  stage_t a_out;

  owbg_div_chain u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_data   (a_in),
    .out_valid (a_valid),
    .out_data  (a_out)
  );

  // green gain choice and the operand of the second division
  stage_t b_in;
  logic [NUM_W-1:0] q0, q1, gsel;
  logic [GOLD_W-1:0] gmul;

  always_comb begin
    q0   = a_out.lane0.quo;
    q1   = a_out.lane1.quo;
    b_in = '0;
    b_in.ctx = a_out.ctx;
    b_in.lane0.den = 11'd1;
    b_in.lane1.den = 11'd1;
    gsel = '0;
    gmul = '0;
    unique case (a_out.ctx.kind)
      K_LOW_BOTH: begin
        b_in.ctx.red = q0;
        b_in.ctx.grn = NUM_W'(UNITY_GAIN);
        b_in.ctx.blu = q1;
        b_in.ctx.tgt = T_NONE;
      end
      K_HIGH_RG: begin
        b_in.ctx.red = NUM_W'(UNITY_GAIN);
        b_in.ctx.grn = q0;
        b_in.ctx.tgt = T_BLUE;
        gsel = q0;
        gmul = a_out.ctx.gbg;
        b_in.lane0.den = a_out.ctx.bg;
      end
      K_HIGH_BG: begin
        b_in.ctx.blu = NUM_W'(UNITY_GAIN);
        b_in.ctx.grn = q0;
        b_in.ctx.tgt = T_RED;
        gsel = q0;
        gmul = a_out.ctx.grg;
        b_in.lane0.den = a_out.ctx.rg;
      end
      K_HIGH_BOTH: begin
        if (q1 > q0) begin
          b_in.ctx.blu = NUM_W'(UNITY_GAIN);
          b_in.ctx.grn = q1;
          b_in.ctx.tgt = T_RED;
          gsel = q1;
          gmul = a_out.ctx.grg;
          b_in.lane0.den = a_out.ctx.rg;
        end else begin
          b_in.ctx.red = NUM_W'(UNITY_GAIN);
          b_in.ctx.grn = q0;
          b_in.ctx.tgt = T_BLUE;
          gsel = q0;
          gmul = a_out.ctx.gbg;
          b_in.lane0.den = a_out.ctx.bg;
        end
      end
      default: begin
        b_in.ctx.tgt = T_NONE;
      end
    endcase
    // first-stage quotients stay below 2^21, so the product fits 32 bits
    b_in.lane0.num = NUM_W'(gsel[21:0]) * NUM_W'(gmul);
  end

  logic   s2_valid_r;
  stage_t s2_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_data_r <= b_in;
  end

  logic   b_valid;
  stage_t b_out;

  owbg_div_chain u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_data   (s2_data_r),
    .out_valid (b_valid),
    .out_data  (b_out)
  );

  // final gains, saturation and apply flags
  out_t res;
  logic [NUM_W-1:0] red_w, blu_w;

  always_comb begin
    red_w = (b_out.ctx.tgt == T_RED)  ? b_out.lane0.quo : b_out.ctx.red;
    blu_w = (b_out.ctx.tgt == T_BLUE) ? b_out.lane0.quo : b_out.ctx.blu;
    res = '0;
    res.status = b_out.ctx.status;
    if (b_out.ctx.status == ST_OK) begin
      res.red_gain    = sat_gain(red_w);
      res.green_gain  = sat_gain(b_out.ctx.grn);
      res.blue_gain   = sat_gain(blu_w);
      res.red_apply   = res.red_gain   > UNITY_GAIN;
      res.green_apply = res.green_gain > UNITY_GAIN;
      res.blue_apply  = res.blue_gain  > UNITY_GAIN;
    end
  end

  logic out_strobe_r;
  out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= res;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the OTP white-balance gain block.
module tb import owbg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 67;
  localparam int CYCLE_CAP = 400000;
  localparam logic [2:0] ADDR_GOLD_RG = 3'd0;
  localparam logic [2:0] ADDR_GOLD_BG = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_strobe;
  out_t        out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  otp_white_balance_gain DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of the golden registers
  logic [9:0] gold_rg;
  logic [9:0] gold_bg;

  out_t gains_due[$];
  int   mismatches;
  int   cycles;
  int   send_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Light correction of one ratio
  function automatic logic [63:0] corrected(logic [9:0] ratio, logic [9:0] light);
    if (light == 10'd0) return 64'(ratio);
    return (64'(ratio) * (64'(light) + 64'd512)) / 64'd1024;
  endfunction

  function automatic logic [23:0] clamp24(logic [63:0] v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  // Expected gains for one OTP group
  function automatic out_t predict_gains(in_t it);
    out_t        o;
    logic [63:0] rg, bg, grg, gbg, r, g, b, gb, gr, u;
    o = '0;
    u = 64'h400;
    r = '0; g = '0; b = '0;
    if (it.group_flag[7:6] == 2'b00) begin
      o.status = ST_EMPTY;
      return o;
    end
    if (it.group_flag[7]) begin
      o.status = ST_INVALID;
      return o;
    end
    rg = corrected({it.rg_high, it.low_bits[7:6]}, {it.light_rg_high, it.low_bits[3:2]});
    bg = corrected({it.bg_high, it.low_bits[5:4]}, {it.light_bg_high, it.low_bits[1:0]});
    grg = 64'(gold_rg);
    gbg = 64'(gold_bg);
    if (rg == 0 || bg == 0 || grg == 0 || gbg == 0) begin
      o.status = ST_ZERO;
      return o;
    end
    if (bg < gbg) begin
      if (rg < grg) begin
        g = u; b = u * gbg / bg; r = u * grg / rg;
      end else begin
        r = u; g = u * rg / grg; b = g * gbg / bg;
      end
    end else if (rg < grg) begin
      b = u; g = u * bg / gbg; r = g * grg / rg;
    end else begin
      gb = u * bg / gbg;
      gr = u * rg / grg;
      if (gb > gr) begin
        b = u; g = gb; r = g * grg / rg;
      end else begin
        r = u; g = gr; b = g * gbg / bg;
      end
    end
    o.red_gain    = clamp24(r);
    o.green_gain  = clamp24(g);
    o.blue_gain   = clamp24(b);
    o.red_apply   = o.red_gain > UNITY_GAIN;
    o.green_apply = o.green_gain > UNITY_GAIN;
    o.blue_apply  = o.blue_gain > UNITY_GAIN;
    o.status      = ST_OK;
    return o;
  endfunction

  // Result checker
  initial begin
    out_t want;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_strobe) begin
        if (gains_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_item);
        end else begin
          want = gains_due.pop_front();
          if (out_item.red_gain !== want.red_gain || out_item.green_gain !== want.green_gain
              || out_item.blue_gain !== want.blue_gain
              || out_item.red_apply !== want.red_apply
              || out_item.green_apply !== want.green_apply
              || out_item.blue_apply !== want.blue_apply
              || out_item.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: want r=%h g=%h b=%h ap=%b%b%b st=%0d",
                        " got r=%h g=%h b=%h ap=%b%b%b st=%0d"},
                       want.red_gain, want.green_gain, want.blue_gain, want.red_apply,
                       want.green_apply, want.blue_apply, want.status,
                       out_item.red_gain, out_item.green_gain, out_item.blue_gain,
                       out_item.red_apply, out_item.green_apply, out_item.blue_apply,
                       out_item.status);
          end
        end
      end
    end
  end

  // Send one item, with a random gap in front; start stays high for the next item
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    gains_due.push_back(predict_gains(it));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (gains_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // APB register write, block idle
  task automatic write_golden(logic [2:0] addr, logic [9:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_GOLD_RG) gold_rg = val; else gold_bg = val;
    @(negedge clk);
  endtask

  function automatic in_t valid_group(logic [5:0] fl_low);
    in_t it;
    it = 48'({$urandom, $urandom});
    it.group_flag = {2'b01, fl_low};
    return it;
  endfunction

  function automatic in_t mixed_group();
    in_t it;
    int  k;
    it = 48'({$urandom, $urandom});
    k = $urandom_range(99);
    if (k < 80) it.group_flag[7:6] = 2'b01;
    if (k < 80 && $urandom_range(3) == 0) begin
      it.light_rg_high = 8'd0; it.low_bits[3:2] = 2'd0;
    end
    if (k < 80 && $urandom_range(3) == 0) begin
      it.light_bg_high = 8'd0; it.low_bits[1:0] = 2'd0;
    end
    if (k < 80 && $urandom_range(15) == 0) begin
      it.rg_high = 8'($urandom_range(1)); it.low_bits[7:6] = 2'($urandom_range(1));
    end
    return it;
  endfunction

  // Flag cases, field extremes, zero ratio, equal green candidates
  task automatic test_directed();
    in_t it;
    it = '0;                           send_item(it);
    it = '1;                           send_item(it);
    it = '1; it.group_flag = 8'h80;    send_item(it);
    it = '1; it.group_flag = 8'h3F;    send_item(it);
    it = '1; it.group_flag = 8'h40;    send_item(it);
    it = '0; it.group_flag = 8'h7F;    send_item(it);
    it = '0; it.group_flag = 8'h40; it.bg_high = 8'hFF; send_item(it);
    it = '0; it.group_flag = 8'h40; it.rg_high = 8'hFF; send_item(it);
    it = '0; it.group_flag = 8'h40; it.low_bits = 8'hF0; send_item(it);
    it = '0; it.group_flag = 8'h40; it.rg_high = 8'd0; it.low_bits = 8'h50;
    it.light_rg_high = 8'h01; send_item(it);
    // exactly golden ratios: both candidates equal
    it = '0; it.group_flag = 8'h40;
    it.rg_high = gold_rg[9:2]; it.bg_high = gold_bg[9:2];
    it.low_bits = {gold_rg[1:0], gold_bg[1:0], 4'h0}; send_item(it);
    it = '0; it.group_flag = 8'h40; it.rg_high = 8'd1; it.bg_high = 8'd1; send_item(it);
    it = '0; it.group_flag = 8'h40; it.rg_high = 8'd1; it.bg_high = 8'hFF; send_item(it);
    it = '0; it.group_flag = 8'h40; it.rg_high = 8'hFF; it.bg_high = 8'd1; send_item(it);
    it = '1; it.group_flag = 8'h55; it.light_rg_high = 8'd0; it.low_bits = 8'hF3;
    send_item(it);
    it = 48'hAA5555AAAAAA; it.group_flag = 8'h6A; send_item(it);
    drain();
  endtask

  // Random groups under one setting of the golden registers
  task automatic test_random(int n, int idle_pct);
    send_idle_pct = idle_pct;
    repeat (n) send_item(mixed_group());
  endtask

  // Extreme golden ratios, then a zero golden ratio
  task automatic test_golden_extremes();
    write_golden(ADDR_GOLD_RG, 10'd1);
    write_golden(ADDR_GOLD_BG, 10'd1023);
    repeat (60) send_item(valid_group(6'($urandom)));
    drain();
    write_golden(ADDR_GOLD_RG, 10'd1023);
    write_golden(ADDR_GOLD_BG, 10'd1);
    repeat (60) send_item(valid_group(6'($urandom)));
    drain();
    write_golden(ADDR_GOLD_RG, 10'd0);
    repeat (10) send_item(valid_group(6'($urandom)));
    drain();
    write_golden(ADDR_GOLD_RG, 10'd279);
    write_golden(ADDR_GOLD_BG, 10'd0);
    repeat (10) send_item(valid_group(6'($urandom)));
    drain();
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gold_rg = 10'd279; gold_bg = 10'd275;
    send_idle_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(450, 29);
    drain();
    write_golden(ADDR_GOLD_RG, 10'($urandom_range(1, 1023)));
    write_golden(ADDR_GOLD_BG, 10'($urandom_range(1, 1023)));
    test_random(450, 51);
    drain();
    test_golden_extremes();
    write_golden(ADDR_GOLD_RG, 10'($urandom_range(100, 600)));
    write_golden(ADDR_GOLD_BG, 10'($urandom_range(100, 600)));
    test_random(450, 0);
    drain();

    if (mismatches == 0 && gains_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: otp_white_balance_gain.f
src/owbg_pkg.sv
src/owbg_div_cell.sv
src/owbg_div_chain.sv
src/otp_white_balance_gain.sv
tb/sv/tb.sv
